/* hw/rtl/mer_pkg.sv */
`default_nettype none

package mer_pkg;

  // Default field widths
  localparam int RADIUS_BITS_DEF = 10;
  localparam int CENTRE_BITS_DEF = 11;

  // Fixed result and arithmetic widths
  localparam int PIX_W       = 13;
  localparam int DEC_W       = 48;
  localparam int OUT_TDATA_W = 32;

  // Entries in the queue between front and back end
  localparam int Q_DEPTH = 2;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQ,
    BK_QMUL,
    BK_QACC,
    BK_SINIT,
    BK_UPD,
    BK_DEC,
    BK_SU0,
    BK_MUL,
    BK_MACC,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

/* hw/rtl/mer_front.sv */
`default_nettype none

module mer_front #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int CENTRE_BITS = mer_pkg::CENTRE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [RADIUS_BITS-1:0]               in_rx,
  input  logic [RADIUS_BITS-1:0]               in_ry,
  input  logic [CENTRE_BITS-1:0]               in_cx,
  input  logic [CENTRE_BITS-1:0]               in_cy,
  output logic                                 f_valid,
  input  logic                                 f_ready,
  output logic [2*RADIUS_BITS+2*CENTRE_BITS:0] f_data
);
  import mer_pkg::*;

  localparam int EW = 2*RADIUS_BITS + 2*CENTRE_BITS + 1;

  logic          fv_r, fv_nxt;
  logic [EW-1:0] fd_r, fd_nxt;
  kind_t         kind;

  // Tag the item as start or step
  assign kind = in_op ? KIND_STEP : KIND_START;

  assign in_ready = !fv_r || f_ready;

  always_comb begin
    fv_nxt = fv_r;
    fd_nxt = fd_r;
    if (in_ready) begin
      fv_nxt = in_valid;
      fd_nxt = {in_cy, in_cx, in_ry, in_rx, kind};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fd_r <= fd_nxt;
  end

  assign f_valid = fv_r;
  assign f_data  = fd_r;

endmodule

`default_nettype wire

/* hw/rtl/mer_queue.sv */
`default_nettype none

module mer_queue #(
  parameter int WIDTH = 2*mer_pkg::RADIUS_BITS_DEF + 2*mer_pkg::CENTRE_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_pop,
  output logic [WIDTH-1:0] m_data
);
  import mer_pkg::*;

  localparam int PTRW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  assign s_ready = (cnt_r != CNTW'(Q_DEPTH));
  assign m_valid = (cnt_r != '0);
  assign push    = s_valid && s_ready;
  assign pop     = m_pop && m_valid;
  assign m_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= s_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mer_back.sv */
`default_nettype none

module mer_back #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int CENTRE_BITS = mer_pkg::CENTRE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  logic [2*RADIUS_BITS+2*CENTRE_BITS:0] q_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mer_pkg::PIX_W-1:0]     out_px,
  output logic signed [mer_pkg::PIX_W-1:0]     out_py,
  output logic                                 out_last,
  output logic                                 out_done
);
  import mer_pkg::*;

  localparam int RB  = RADIUS_BITS;
  localparam int CB  = CENTRE_BITS;
  localparam int XW  = RB + 1;       // working x
  localparam int YW  = RB + 2;       // working y, signed
  localparam int SQW = 2 * RB;       // squared radii
  localparam int PW  = 3 * RB + 1;   // x * ry^2, exact
  localparam int QW  = 3 * RB + 2;   // y * rx^2, exact, signed
  localparam int AW  = 2 * RB + 2;   // multiplier operand a, signed
  localparam int HW  = DEC_W / 2;    // multiplier slice of operand b
  localparam int MW  = AW + HW + 1;  // partial product

  typedef enum logic [2:0] {
    MP_XP_LO,
    MP_XP_HI,
    MP_RR_LO,
    MP_RR_HI,
    MP_YQ_LO,
    MP_YQ_HI
  } mpart_t;

  // Control
  bk_state_t state_r, state_nxt;
  logic      active_r, active_nxt;
  logic      ov_r, ov_nxt;
  logic [1:0] pt_r, pt_nxt;
  mpart_t    mp_r, mp_nxt;

  // Datapath
  logic [RB-1:0]           hrx_r, hrx_nxt, hry_r, hry_nxt;
  logic [CB-1:0]           hcx_r, hcx_nxt, hcy_r, hcy_nxt;
  logic [XW-1:0]           x_r, x_nxt;
  logic signed [YW-1:0]    y_r, y_nxt;
  logic [PW-1:0]           p_r, p_nxt;
  logic signed [QW-1:0]    q_r, q_nxt;
  logic [DEC_W-1:0]        d_r, d_nxt;
  logic [DEC_W-1:0]        dacc_r, dacc_nxt;
  logic [DEC_W-1:0]        qm_r, qm_nxt;
  logic [SQW-1:0]          rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic                    r2_r, r2_nxt;
  logic                    inc_r, inc_nxt, dec_r, dec_nxt;
  logic                    done_r, done_nxt;
  logic signed [MW-1:0]    prod_r;
  logic                    phi_r, psub_r;
  logic signed [PIX_W-1:0] opx_r, opx_nxt, opy_r, opy_nxt;
  logic                    olast_r, olast_nxt, odone_r, odone_nxt;

  // Queue entry fields
  kind_t         q_kind;
  logic [RB-1:0] q_rx, q_ry;
  logic [CB-1:0] q_cx, q_cy;

  // Helpers
  logic                 neg, le0, more, y_le0;
  logic signed [YW-1:0] ym1;
  logic [DEC_W-1:0]     p48, q48, rx2_48, ry2_48, prod48, term, term4, acc_sum, d_step;
  logic signed [AW-1:0] mul_a;
  logic [HW-1:0]        mul_b;
  logic                 mul_hi, mul_sub;
  logic signed [MW-1:0] prod_nxt;
  logic [31:0]          cx32, cy32, x32, y32, sx, sy;

  assign q_kind = kind_t'(q_data[0]);
  assign q_rx   = q_data[RB:1];
  assign q_ry   = q_data[2*RB:RB+1];
  assign q_cx   = q_data[2*RB+CB:2*RB+1];
  assign q_cy   = q_data[2*RB+2*CB:2*RB+CB+1];

  assign neg    = d_r[DEC_W-1];
  assign le0    = neg || (d_r == '0);
  assign ym1    = y_r - YW'(1);
  assign y_le0  = y_r[YW-1] || (y_r == '0);
  assign more   = ($signed(QW'(p_r)) <= q_r) && !y_r[YW-1];

  assign p48    = DEC_W'(p_r);
  assign q48    = DEC_W'(q_r);
  assign rx2_48 = DEC_W'(rx2_r);
  assign ry2_48 = DEC_W'(ry2_r);

  // One midpoint update of the decision, from the stepped x*ry^2 and y*rx^2
  assign d_step = d_r + (inc_r ? (p48 << 3) : '0)
                + (r2_r ? (rx2_48 << 2) : (ry2_48 << 2))
                - (dec_r ? (q48 << 3) : '0);

  // Shared multiplier: operand a times one 24-bit slice of operand b
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_hi  = 1'b0;
    mul_sub = 1'b0;
    if (state_r == BK_QMUL) begin
      mul_a = $signed(AW'(rx2_r));
      mul_b = HW'(hry_r);
    end else begin
      case (mp_r)
        MP_XP_LO: begin
          mul_a = $signed(AW'(x_r));
          mul_b = p48[HW-1:0];
        end
        MP_XP_HI: begin
          mul_a  = $signed(AW'(x_r));
          mul_b  = p48[DEC_W-1:HW];
          mul_hi = 1'b1;
        end
        MP_RR_LO: begin
          mul_a   = $signed(AW'(rx2_r));
          mul_b   = ry2_48[HW-1:0];
          mul_sub = 1'b1;
        end
        MP_RR_HI: begin
          mul_a   = $signed(AW'(rx2_r));
          mul_b   = ry2_48[DEC_W-1:HW];
          mul_hi  = 1'b1;
          mul_sub = 1'b1;
        end
        MP_YQ_LO: begin
          mul_a = AW'(ym1);
          mul_b = qm_r[HW-1:0];
        end
        MP_YQ_HI: begin
          mul_a  = AW'(ym1);
          mul_b  = qm_r[DEC_W-1:HW];
          mul_hi = 1'b1;
        end
        default: begin
          mul_a = '0;
        end
      endcase
    end
  end

  assign prod_nxt = MW'(mul_a) * MW'($signed({1'b0, mul_b}));

  // Fold the previous partial product, times four, into the accumulator
  assign prod48  = DEC_W'(prod_r);
  assign term    = phi_r ? {prod48[HW-1:0], HW'(0)} : prod48;
  assign term4   = term << 2;
  assign acc_sum = psub_r ? (dacc_r - term4) : (dacc_r + term4);

  // Mirrored point selected by the point counter
  assign cx32 = 32'(hcx_r);
  assign cy32 = 32'(hcy_r);
  assign x32  = 32'(x_r);
  assign y32  = 32'(y_r);
  assign sx   = pt_r[0] ? (cx32 - x32) : (cx32 + x32);
  assign sy   = pt_r[1] ? (cy32 - y32) : (cy32 + y32);

  assign q_pop = (state_r == BK_IDLE) && q_valid;

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    pt_nxt     = pt_r;
    mp_nxt     = mp_r;
    hrx_nxt    = hrx_r;
    hry_nxt    = hry_r;
    hcx_nxt    = hcx_r;
    hcy_nxt    = hcy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    d_nxt      = d_r;
    dacc_nxt   = dacc_r;
    qm_nxt     = qm_r;
    rx2_nxt    = rx2_r;
    ry2_nxt    = ry2_r;
    r2_nxt     = r2_r;
    inc_nxt    = inc_r;
    dec_nxt    = dec_r;
    done_nxt   = done_r;
    ov_nxt     = ov_r && !out_ready;
    opx_nxt    = opx_r;
    opy_nxt    = opy_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_kind == KIND_START) begin
            hrx_nxt    = q_rx;
            hry_nxt    = q_ry;
            hcx_nxt    = q_cx;
            hcy_nxt    = q_cy;
            x_nxt      = '0;
            y_nxt      = $signed(YW'(q_ry));
            p_nxt      = '0;
            r2_nxt     = 1'b0;
            active_nxt = 1'b1;
            state_nxt  = BK_SQ;
          end else if (active_r) begin
            state_nxt = BK_UPD;
          end
        end
      end
      BK_SQ: begin
        rx2_nxt   = SQW'(hrx_r) * SQW'(hrx_r);
        ry2_nxt   = SQW'(hry_r) * SQW'(hry_r);
        state_nxt = BK_QMUL;
      end
      BK_QMUL: begin
        state_nxt = BK_QACC;
      end
      BK_QACC: begin
        q_nxt     = QW'(prod_r);
        state_nxt = BK_SINIT;
      end
      BK_SINIT: begin
        d_nxt     = (ry2_48 << 2) - (q48 << 2) + rx2_48;
        done_nxt  = 1'b0;
        pt_nxt    = '0;
        state_nxt = BK_EMIT;
      end
      BK_UPD: begin
        if (!r2_r) begin
          inc_nxt = 1'b1;
          dec_nxt = !neg;
        end else begin
          inc_nxt = le0;
          dec_nxt = 1'b1;
        end
        if (inc_nxt) begin
          x_nxt = x_r + XW'(1);
          p_nxt = p_r + PW'(ry2_r);
        end
        if (dec_nxt) begin
          y_nxt = y_r - YW'(1);
          q_nxt = q_r - $signed(QW'(rx2_r));
        end
        state_nxt = BK_DEC;
      end
      BK_DEC: begin
        if (!r2_r && !more) begin
          state_nxt = BK_SU0;
        end else begin
          d_nxt    = d_step;
          done_nxt = r2_r && y_le0;
          if (r2_r && y_le0) begin
            active_nxt = 1'b0;
          end
          pt_nxt    = '0;
          state_nxt = BK_EMIT;
        end
      end
      BK_SU0: begin
        dacc_nxt  = (p48 << 2) + ry2_48;
        qm_nxt    = q48 - rx2_48;
        mp_nxt    = MP_XP_LO;
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        if (mp_r != MP_XP_LO) begin
          dacc_nxt = acc_sum;
        end
        if (mp_r == MP_YQ_HI) begin
          state_nxt = BK_MACC;
        end else begin
          mp_nxt = mpart_t'(mp_r + 3'd1);
        end
      end
      BK_MACC: begin
        d_nxt    = acc_sum;
        r2_nxt   = 1'b1;
        done_nxt = y_le0;
        if (y_le0) begin
          active_nxt = 1'b0;
        end
        pt_nxt    = '0;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          opx_nxt   = $signed(sx[PIX_W-1:0]);
          opy_nxt   = $signed(sy[PIX_W-1:0]);
          olast_nxt = (pt_r == 2'd3);
          odone_nxt = done_r;
          pt_nxt    = pt_r + 2'd1;
          if (pt_r == 2'd3) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      pt_r     <= '0;
      mp_r     <= MP_XP_LO;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
      pt_r     <= pt_nxt;
      mp_r     <= mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hrx_r   <= hrx_nxt;
    hry_r   <= hry_nxt;
    hcx_r   <= hcx_nxt;
    hcy_r   <= hcy_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    d_r     <= d_nxt;
    dacc_r  <= dacc_nxt;
    qm_r    <= qm_nxt;
    rx2_r   <= rx2_nxt;
    ry2_r   <= ry2_nxt;
    r2_r    <= r2_nxt;
    inc_r   <= inc_nxt;
    dec_r   <= dec_nxt;
    done_r  <= done_nxt;
    prod_r  <= prod_nxt;
    phi_r   <= mul_hi;
    psub_r  <= mul_sub;
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid = ov_r;
  assign out_px    = opx_r;
  assign out_py    = opy_r;
  assign out_last  = olast_r;
  assign out_done  = odone_r;

endmodule

`default_nettype wire

/* hw/rtl/midpoint_ellipse_rasterizer_top.sv */
`default_nettype none

// Midpoint ellipse rasterizer. Send a start item (tuser = 0) carrying both
// semi-axes and the centre; the block answers with the four mirrored points
// of (0, radius_y). Each step item (tuser = 1) advances the ellipse by one
// midpoint iteration and returns four more points, in the order (+x,+y),
// (-x,+y), (+x,-y), (-x,-y), with tlast on the fourth and tuser set on all
// four points of the step that finishes the ellipse. Steps sent while no
// ellipse is running are dropped without output; a start while one runs
// replaces it. Coordinates wrap to 13-bit two's complement. A front
// register and a two-entry queue take items in while the back-end sequencer
// works, and the back end handles one item at a time. A step item is
// fetched, advances x and y, updates the decision and makes four point
// transfers; the step that leaves region 1 instead forms the region 2
// decision with the shared multiplier in six 24-bit partial products; a
// start item squares the radii, forms y*rx^2 from one partial product,
// sets up the decision and makes four point transfers. Output
// backpressure stalls the point transfers.
module midpoint_ellipse_rasterizer_top #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int CENTRE_BITS = mer_pkg::CENTRE_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  // in_tdata, from bit 0: radius_x, radius_y, centre_x, centre_y, zero pad
  input  logic [((2*RADIUS_BITS+2*CENTRE_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: op (0 = start, 1 = step)
  input  logic                                                 in_tuser,
  input  logic                                                 in_tvalid,
  output logic                                                 in_tready,
  // out_tdata, from bit 0: pixel_x, pixel_y, zero pad
  output logic [mer_pkg::OUT_TDATA_W-1:0]                      out_tdata,
  // out_tuser: done_res
  output logic                                                 out_tuser,
  output logic                                                 out_tlast,
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready
);
  import mer_pkg::*;

  localparam int RB = RADIUS_BITS;
  localparam int CB = CENTRE_BITS;
  localparam int EW = 2*RB + 2*CB + 1;

  // Front to queue
  logic          f_valid, f_ready;
  logic [EW-1:0] f_data;

  // Queue to back end
  logic          q_valid, q_pop;
  logic [EW-1:0] q_data;

  logic signed [PIX_W-1:0] px, py;

  // Accept and tag items
  mer_front #(
    .RADIUS_BITS(RB),
    .CENTRE_BITS(CB)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_rx    (in_tdata[RB-1:0]),
    .in_ry    (in_tdata[2*RB-1:RB]),
    .in_cx    (in_tdata[2*RB+CB-1:2*RB]),
    .in_cy    (in_tdata[2*RB+2*CB-1:2*RB+CB]),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  // Hold items while the back end is busy
  mer_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (q_valid),
    .m_pop   (q_pop),
    .m_data  (q_data)
  );

  // Run the midpoint iterations and transfer the points
  mer_back #(
    .RADIUS_BITS(RB),
    .CENTRE_BITS(CB)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_px    (px),
    .out_py    (py),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = {(OUT_TDATA_W - 2*PIX_W)'(0), py, px};

endmodule

`default_nettype wire

/* hw/rtl/mer_checker.sv */
`default_nettype none

module mer_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic [mer_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import mer_pkg::*;

  logic       out_xfer;
  logic [1:0] cnt_r;
  logic       user_r;

  assign out_xfer = out_tvalid && out_tready;

  // Track the position of each point within its item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      user_r <= 1'b0;
    end else if (out_xfer) begin
      cnt_r  <= cnt_r + 2'd1;
      user_r <= out_tuser;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_last_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (out_tlast == (cnt_r == 2'd3)))
    else $error("tlast not on the fourth point of an item");

  a_done_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (cnt_r != 2'd0) |-> (out_tuser == user_r))
    else $error("done flag differs within one item");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

/* tb/midpoint_ellipse_rasterizer_top_tb.sv */
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_tb;
  import mer_pkg::*;

  localparam int RB    = RADIUS_BITS_DEF;
  localparam int CB    = CENTRE_BITS_DEF;
  localparam int IN_W  = ((2 * RB + 2 * CB + 7) / 8) * 8;
  localparam int LIMIT = 300000;

  // One input item: op travels on tuser, the rest packed into tdata.
  typedef struct {
    kind_t         op;
    logic [RB-1:0] radius_x;
    logic [RB-1:0] radius_y;
    logic [CB-1:0] centre_x;
    logic [CB-1:0] centre_y;
  } ellipse_cmd_t;

  // One plotted point as it leaves the block.
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last;
    logic                    done;
  } plot_point_t;

  logic            clk;
  logic            rst_n      = 1'b0;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            in_tuser   = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic            out_tuser;
  logic            out_tlast;
  logic            out_tvalid;
  logic            out_tready = 1'b0;

  ellipse_cmd_t ellipse_cmds[$];   // items not yet put on the bus
  ellipse_cmd_t on_bus;            // item currently offered on the input channel
  plot_point_t  plot_points[$];    // points still owed by the block

  int cmds_taken = 0;
  int total_cmds = 1;
  int mismatches = 0;
  int cycles     = 0;

  // Predictor state: working point, scaled decision, region and held setup.
  longint          pt_x;
  longint          pt_y;
  logic [DEC_W-1:0] dec_acc;
  bit              region_two;
  bit              drawing;
  logic [RB-1:0]   hold_rx;
  logic [RB-1:0]   hold_ry;
  logic [CB-1:0]   hold_cx;
  logic [CB-1:0]   hold_cy;

  midpoint_ellipse_rasterizer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle percentage per side: sender nearly always sending and sink mostly
  // idle first, then the reverse, then full rate on both sides for the last third.
  function automatic int idle_pct(input bit sink_side);
    int ph;
    ph = (cmds_taken * 3) / total_cmds;
    if (ph == 0) return sink_side ? 82 : 6;
    if (ph == 1) return sink_side ? 6 : 82;
    return 0;
  endfunction

  // Queue the four mirrored points of the current working point.
  task automatic mirror_points(input bit fin);
    longint      cxl;
    longint      cyl;
    longint      px;
    longint      py;
    plot_point_t p;
    cxl = longint'(hold_cx);
    cyl = longint'(hold_cy);
    for (int k = 0; k < 4; k++) begin
      px = (k % 2 == 0) ? cxl + pt_x : cxl - pt_x;
      py = (k < 2) ? cyl + pt_y : cyl - pt_y;
      p.pixel_x = px[PIX_W-1:0];
      p.pixel_y = py[PIX_W-1:0];
      p.last    = (k == 3);
      p.done    = fin;
      plot_points.push_back(p);
    end
  endtask

  // Advance the midpoint-ellipse model by one accepted item and queue
  // whatever points it produces.
  task automatic trace_ellipse(input ellipse_cmd_t c);
    longint unsigned rxl, ryl, rx2, ry2, ux, uy, acc, t, ym;
    longint          lhs, rhs;
    bit              neg, le0, fin;
    fin = 1'b0;
    if (c.op == KIND_START) begin
      hold_rx = c.radius_x;
      hold_ry = c.radius_y;
      hold_cx = c.centre_x;
      hold_cy = c.centre_y;
      rxl = 64'(hold_rx);
      ryl = 64'(hold_ry);
      rx2 = rxl * rxl;
      ry2 = ryl * ryl;
      pt_x = 0;
      pt_y = ryl;
      acc = 4 * ry2 - 4 * rx2 * ryl + rx2;
      dec_acc = acc[DEC_W-1:0];
      region_two = 1'b0;
      drawing = 1'b1;
      mirror_points(1'b0);
      return;
    end
    // Drop steps while nothing is being drawn.
    if (!drawing) return;
    rxl = 64'(hold_rx);
    ryl = 64'(hold_ry);
    rx2 = rxl * rxl;
    ry2 = ryl * ryl;
    if (!region_two) begin
      neg = dec_acc[DEC_W-1];
      pt_x = pt_x + 1;
      if (!neg) pt_y = pt_y - 1;
      ux = pt_x;
      uy = pt_y;
      acc = dec_acc;
      acc = acc + 8 * ry2 * ux + 4 * ry2;
      if (!neg) acc = acc - 8 * rx2 * uy;
      dec_acc = acc[DEC_W-1:0];
      lhs = pt_x * longint'(ry2);
      rhs = pt_y * longint'(rx2);
      // Leave region 1 once the slope passes -1 or y has gone negative.
      if (!((lhs <= rhs) && (pt_y >= 0))) begin
        t = 2 * ux + 1;
        ym = uy - 1;
        region_two = 1'b1;
        acc = ry2 * t * t - 4 * rx2 * ry2 + 4 * rx2 * ym * ym;
        dec_acc = acc[DEC_W-1:0];
        fin = (pt_y <= 0);
      end
    end else begin
      le0 = dec_acc[DEC_W-1] || (dec_acc == '0);
      if (le0) pt_x = pt_x + 1;
      pt_y = pt_y - 1;
      ux = pt_x;
      uy = pt_y;
      acc = dec_acc;
      acc = acc + 4 * rx2 - 8 * rx2 * uy;
      if (le0) acc = acc + 8 * ry2 * ux;
      dec_acc = acc[DEC_W-1:0];
      fin = (pt_y <= 0);
    end
    if (fin) drawing = 1'b0;
    mirror_points(fin);
  endtask

  // Append a start item followed by a run of step items; the step payload
  // is ignored by the block, so fill it with noise.
  task automatic queue_ellipse(input int rx, input int ry, input int cx, input int cy,
                               input int steps);
    ellipse_cmd_t c;
    c.op       = KIND_START;
    c.radius_x = RB'(rx);
    c.radius_y = RB'(ry);
    c.centre_x = CB'(cx);
    c.centre_y = CB'(cy);
    ellipse_cmds.push_back(c);
    for (int i = 0; i < steps; i++) begin
      c.op       = KIND_STEP;
      c.radius_x = RB'($urandom);
      c.radius_y = RB'($urandom);
      c.centre_x = CB'($urandom);
      c.centre_y = CB'($urandom);
      ellipse_cmds.push_back(c);
    end
  endtask

  // Driver: hold the offered item until it transfers, then predict it and
  // offer the next one unless the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        trace_ellipse(on_bus);
        cmds_taken <= cmds_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (ellipse_cmds.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          on_bus = ellipse_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.op;
          in_tdata  <= IN_W'({on_bus.centre_y, on_bus.centre_x,
                              on_bus.radius_y, on_bus.radius_x});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the output at random and compare every transfer with
  // the oldest owed point.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        plot_point_t got;
        plot_point_t want;
        got.pixel_x = out_tdata[PIX_W-1:0];
        got.pixel_y = out_tdata[2*PIX_W-1:PIX_W];
        got.last    = out_tlast;
        got.done    = out_tuser;
        if (plot_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0b done=%0b", $time,
                   got.pixel_x, got.pixel_y, got.last, got.done);
          mismatches <= mismatches + 1;
        end else begin
          want = plot_points.pop_front();
          if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.last !== want.last || got.done !== want.done) begin
            $display("%0t: point mismatch: expected x=%0d y=%0d last=%0b done=%0b",
                     $time, want.pixel_x, want.pixel_y, want.last, want.done);
            $display("%0t:                 actual   x=%0d y=%0d last=%0b done=%0b",
                     $time, got.pixel_x, got.pixel_y, got.last, got.done);
            mismatches <= mismatches + 1;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[midpoint_ellipse_rasterizer_top] ERROR");
      $finish;
    end
  end

  initial begin
    int   kind;
    int   rx;
    int   ry;
    ellipse_cmd_t c;

    // Directed part. A step right after reset must be dropped.
    c.op = KIND_STEP;
    c.radius_x = '1;
    c.radius_y = '1;
    c.centre_x = '1;
    c.centre_y = '1;
    ellipse_cmds.push_back(c);
    // Both radii zero: one step finishes, the next is dropped.
    queue_ellipse(0, 0, 0, 0, 2);
    // Largest radii and centre, cut short by the next start.
    queue_ellipse(1023, 1023, 2047, 2047, 2);
    // Wide and flat: region 1 ends on the first step, which also finishes.
    queue_ellipse(1023, 0, 0, 2047, 2);
    // Tall and thin: region 2 right away, points below zero wrap.
    queue_ellipse(0, 1023, 2047, 0, 3);
    // Unit circle run to completion plus dropped steps after it finishes.
    queue_ellipse(1, 1, 5, 5, 4);

    // Random part: mostly complete small ellipses, some interrupted ones
    // and a few with full-range radii that only take a handful of steps.
    while (ellipse_cmds.size() < 220) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        queue_ellipse(rx, ry, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      rx + ry + $urandom_range(1, 4));
      end else if (kind < 85) begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        queue_ellipse(rx, ry, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, rx + ry));
      end else begin
        queue_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(1, 6));
      end
    end
    total_cmds = ellipse_cmds.size();

    // Hold reset, then release.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain the stimulus, then the owed points, then let stray output show.
    while (ellipse_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (plot_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && plot_points.size() == 0) begin
      $display("[midpoint_ellipse_rasterizer_top] OK");
    end else begin
      $display("[midpoint_ellipse_rasterizer_top] ERROR");
    end
    $finish;
  end

endmodule
